// ===== rtl/aifp_pkg.sv =====
package aifp_pkg;

   typedef enum logic [4:0] {
      PH_SKIP   = 5'b00001,
      PH_SIGN   = 5'b00010,
      PH_ZERO   = 5'b00100,
      PH_AFTERX = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   localparam logic [2:0] CONV_SDEC = 3'd0;
   localparam logic [2:0] CONV_AUTO = 3'd1;
   localparam logic [2:0] CONV_OCT  = 3'd2;
   localparam logic [2:0] CONV_HEX  = 3'd3;
   localparam logic [2:0] CONV_UDEC = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_DIGITS = 2'd1;
   localparam logic [1:0] ST_END_EARLY = 2'd2;

   localparam logic [1:0] REG_CONVERSION  = 2'd0;
   localparam logic [1:0] REG_MAX_WIDTH   = 2'd1;
   localparam logic [1:0] REG_RESULT_SIZE = 2'd2;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   typedef struct packed {
      logic       at_end;
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
      logic       is_x;
      logic [4:0] digit;
   } item_type;

   localparam int ITEM_BITS = $bits(item_type);

endpackage

// ===== rtl/aifp_fifo.sv =====
module aifp_fifo
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 2)
   (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
   );

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = CNT_BITS'(count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not rise on push");

endmodule

// ===== rtl/aifp_front.sv =====
module aifp_front
   import aifp_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_ch,
   input  logic       req_at_end,
   input  logic       push,
   output logic       full,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_take
   );

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;

   item_type             cls;
   logic [ITEM_BITS-1:0] q_data;
   logic                 q_empty;

   always_comb begin
      cls.at_end   = req_at_end;
      cls.is_space = (req_ch == CH_SPACE) || (req_ch inside {[CH_TAB:CH_CR]});
      cls.is_plus  = (req_ch == CH_PLUS);
      cls.is_minus = (req_ch == CH_MINUS);
      cls.is_x     = (req_ch == CH_UX) || (req_ch == CH_LX);
      if (req_ch inside {[CH_0:CH_9]}) begin
         cls.digit = 5'(req_ch - CH_0);
      end else if (req_ch inside {[CH_UA:CH_UF]}) begin
         cls.digit = 5'(req_ch - CH_UA + 8'd10);
      end else if (req_ch inside {[CH_LA:CH_LF]}) begin
         cls.digit = 5'(req_ch - CH_LA + 8'd10);
      end else begin
         cls.digit = NO_DIGIT;
      end
   end

   aifp_fifo #(.WIDTH(ITEM_BITS), .DEPTH(2)) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cls),
      .full    (full),
      .pop     (item_take),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   assign item_valid = !q_empty;
   assign item       = item_type'(q_data);

endmodule

// ===== rtl/aifp_back.sv =====
module aifp_back
   import aifp_pkg::*;
   #(parameter int VALUE_BITS = 32,
     parameter int WIDTH_BITS = 8)
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            conversion,
   input  logic [WIDTH_BITS-1:0] max_width,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_take,
   input  logic                  out_ready,
   output logic                  emit,
   output logic [VALUE_BITS-1:0] mag_o,
   output logic                  neg_o,
   output logic [1:0]            status_o,
   output logic [7:0]            consumed_o,
   output logic [1:0]            returned_o
   );

   localparam int CNT_BITS = WIDTH_BITS + 1;
   localparam int CW       = (CNT_BITS > 8) ? CNT_BITS : 8;

   phase_type             phase_ff, phase_in;
   base_type              base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  negative_ff, negative_in;
   logic                  sign_seen_ff, sign_seen_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  step;
   logic [1:0]            status;
   logic [CNT_BITS-1:0]   used;
   logic [CW-1:0]         used_ext;
   logic [1:0]            back;
   logic [CNT_BITS-1:0]   cnt_inc;
   logic [2:0]            conv_eff;

   logic                  sn_zero_pref, sn_digit_ok, sn_sign;
   base_type              sn_base;
   logic [CNT_BITS-1:0]   sn_count;

   base_type              ds_base;
   logic                  ds_digit_ok;
   logic [VALUE_BITS-1:0] ds_acc;

   function automatic logic width_full(input logic [CNT_BITS-1:0] cnt,
                                       input logic [WIDTH_BITS-1:0] w);
      return (w != '0) && (cnt >= {1'b0, w});
   endfunction

   function automatic logic [4:0] base_limit(input base_type b);
      logic [4:0] lim;
      case (b)
         BASE_OCT: lim = 5'd8;
         BASE_HEX: lim = 5'd16;
         default:  lim = 5'd10;
      endcase
      return lim;
   endfunction

   function automatic logic [VALUE_BITS-1:0] mul_add(input logic [VALUE_BITS-1:0] a,
                                                     input base_type b,
                                                     input logic [4:0] d);
      logic [VALUE_BITS-1:0] r;
      case (b)
         BASE_OCT: r = (a << 3) + VALUE_BITS'(d);
         BASE_HEX: r = (a << 4) + VALUE_BITS'(d);
         default:  r = (a << 3) + (a << 1) + VALUE_BITS'(d);
      endcase
      return r;
   endfunction

   assign step      = item_valid && out_ready;
   assign item_take = step;
   assign cnt_inc   = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign conv_eff  = (conversion > CONV_UDEC) ? CONV_SDEC : conversion;

   // first character after any sign
   assign sn_count     = (phase_ff == PH_SKIP) ? CNT_BITS'(1) : cnt_inc;
   assign sn_sign      = (phase_ff == PH_SKIP) ? 1'b0 : sign_seen_ff;
   assign sn_zero_pref = ((conv_eff == CONV_AUTO) || (conv_eff == CONV_HEX))
                         && (item.digit == 5'd0);

   always_comb begin
      case (conv_eff)
         CONV_AUTO: begin
            if (sn_zero_pref) begin
               sn_base = BASE_OCT;
            end else begin
               sn_base = (item.digit < 5'd10) ? BASE_DEC : BASE_HEX;
            end
         end
         CONV_OCT: sn_base = BASE_OCT;
         CONV_HEX: sn_base = BASE_HEX;
         default:  sn_base = BASE_DEC;
      endcase
   end

   assign sn_digit_ok = sn_zero_pref || (item.digit < base_limit(sn_base));

   // digit after the field has started
   assign ds_base     = (phase_ff == PH_AFTERX) ? BASE_HEX : base_ff;
   assign ds_digit_ok = item.digit < base_limit(ds_base);
   assign ds_acc      = mul_add(acc_ff, ds_base, item.digit);

   always_comb begin
      phase_in     = phase_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      negative_in  = negative_ff;
      sign_seen_in = sign_seen_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      status       = ST_OK;
      used         = count_ff;
      back         = 2'd0;
      case (phase_ff)
         PH_SKIP, PH_SIGN: begin
            if (item.at_end) begin
               emit   = 1'b1;
               status = (phase_ff == PH_SKIP) ? ST_END_EARLY : ST_NO_DIGITS;
               back   = (phase_ff == PH_SKIP) ? 2'd0 : 2'd1;
            end else if ((phase_ff == PH_SKIP) && item.is_space) begin
               phase_in = PH_SKIP;
            end else if ((phase_ff == PH_SKIP) && (item.is_plus ||
                         (item.is_minus && (conversion != CONV_UDEC)))) begin
               sign_seen_in = 1'b1;
               negative_in  = item.is_minus;
               phase_in     = PH_SIGN;
               count_in     = CNT_BITS'(1);
               if (width_full(CNT_BITS'(1), max_width)) begin
                  emit   = 1'b1;
                  status = ST_NO_DIGITS;
                  back   = 2'd1;
               end
            end else begin
               if (phase_ff == PH_SKIP) begin
                  sign_seen_in = 1'b0;
                  negative_in  = 1'b0;
               end
               count_in = sn_count;
               base_in  = sn_base;
               if (!sn_digit_ok) begin
                  emit   = 1'b1;
                  status = ST_NO_DIGITS;
                  back   = sn_sign ? 2'd2 : 2'd1;
               end else begin
                  acc_in   = sn_zero_pref ? '0 : VALUE_BITS'(item.digit);
                  phase_in = sn_zero_pref ? PH_ZERO : PH_DIGITS;
                  if (width_full(sn_count, max_width)) begin
                     emit = 1'b1;
                     used = sn_count;
                  end
               end
            end
         end
         PH_ZERO, PH_AFTERX, PH_DIGITS: begin
            if (item.at_end) begin
               emit = 1'b1;
               if (phase_ff == PH_AFTERX) begin
                  used = count_ff - 1'b1;
                  back = 2'd1;
               end
            end else if ((phase_ff == PH_ZERO) && item.is_x) begin
               count_in = cnt_inc;
               phase_in = PH_AFTERX;
               if (width_full(cnt_inc, max_width)) begin
                  emit = 1'b1;
                  used = cnt_inc - 1'b1;
                  back = 2'd1;
               end
            end else if ((phase_ff == PH_AFTERX) && (item.digit == NO_DIGIT)) begin
               emit = 1'b1;
               used = count_ff - 1'b1;
               back = 2'd2;
            end else if (!ds_digit_ok) begin
               emit = 1'b1;
               back = 2'd1;
            end else begin
               count_in = cnt_inc;
               acc_in   = ds_acc;
               base_in  = ds_base;
               phase_in = PH_DIGITS;
               if (width_full(cnt_inc, max_width)) begin
                  emit = 1'b1;
                  used = cnt_inc;
               end
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase
   end

   assign used_ext   = CW'(used);
   assign status_o   = status;
   assign returned_o = back;
   assign neg_o      = negative_in;
   assign mag_o      = (status == ST_OK) ? acc_in : '0;
   assign consumed_o = (status != ST_OK) ? 8'd0 :
                       (used_ext > CW'(255)) ? 8'hFF : used_ext[7:0];

   always_ff @(posedge clock) begin
      if (reset || (step && emit)) begin
         phase_ff     <= PH_SKIP;
         base_ff      <= BASE_DEC;
         acc_ff       <= '0;
         negative_ff  <= 1'b0;
         sign_seen_ff <= 1'b0;
         count_ff     <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         acc_ff       <= acc_in;
         negative_ff  <= negative_in;
         sign_seen_ff <= sign_seen_in;
         count_ff     <= count_in;
      end
   end

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> count_ff == '0 && acc_ff == '0 && !sign_seen_ff)
      else $error("field state not clear while skipping");

   a_sign_seen: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SIGN |-> sign_seen_ff && count_ff != '0)
      else $error("sign phase without sign");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      step && emit && status_o != ST_OK |-> mag_o == '0 && consumed_o == 8'd0)
      else $error("failed conversion carries data");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> phase_ff == PH_SKIP)
      else $error("field did not restart after result");

endmodule

// ===== rtl/ascii_integer_field_parser.sv =====
// Parses one integer field at a time from a stream of characters, one character per
// transfer on the req side, in the manner of a scanf integer conversion: leading
// whitespace is skipped, an optional sign and (hex or auto base) 0x prefix are taken,
// and digits are accumulated until a non-digit, the end mark or the field width ends
// the field, which yields one transfer on the rsp side. Registers: conversion at 0x0
// (0 signed decimal, 1 auto base, 2 octal, 3 hex, 4 unsigned decimal), max_width at
// 0x4 (0 unlimited), result_size at 0x8 (0 truncate to 16 bits). Write them only while
// no field is being delivered. The block takes one character every cycle while full is
// low; a small queue sits after the character classifier and another after the
// shift-add step, so an accepted character is held in the item queue and the result
// of its field in the response queue, and each side can stall on its own.
module ascii_integer_field_parser
   import aifp_pkg::*;
   #(parameter int VALUE_BITS = 32,
     parameter int WIDTH_BITS = 8)
   (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_ch,
   input  logic        req_at_end,
   input  logic        push,
   output logic        full,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_consumed,
   output logic [1:0]  rsp_returned,
   output logic        empty,
   input  logic        pop,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
   );

   localparam int RSP_BITS = VALUE_BITS + 13;
   localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

   logic [2:0]            conversion_ff;
   logic [WIDTH_BITS-1:0] max_width_ff;
   logic                  result_size_ff;
   logic                  csr_write;
   logic [1:0]            csr_index;

   logic                  item_valid, item_take;
   item_type              item;

   logic                  emit, out_full;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic [1:0]            status;
   logic [7:0]            consumed;
   logic [1:0]            returned;
   logic [RSP_BITS-1:0]   rsp_data;

   logic [VALUE_BITS-1:0] head_mag, head_signed;
   logic                  head_neg;
   logic [EXT_BITS-1:0]   head_ext;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         conversion_ff  <= CONV_SDEC;
         max_width_ff   <= '0;
         result_size_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_CONVERSION:  conversion_ff  <= pwdata[2:0];
            REG_MAX_WIDTH:   max_width_ff   <= pwdata[WIDTH_BITS-1:0];
            REG_RESULT_SIZE: result_size_ff <= pwdata[0];
            default:         conversion_ff  <= conversion_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CONVERSION:  prdata = 32'(conversion_ff);
         REG_MAX_WIDTH:   prdata = 32'(max_width_ff);
         REG_RESULT_SIZE: prdata = 32'(result_size_ff);
         default:         prdata = '0;
      endcase
   end

   aifp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .req_at_end (req_at_end),
      .push       (push),
      .full       (full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   aifp_back #(.VALUE_BITS(VALUE_BITS), .WIDTH_BITS(WIDTH_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .conversion (conversion_ff),
      .max_width  (max_width_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_ready  (!out_full),
      .emit       (emit),
      .mag_o      (mag),
      .neg_o      (neg),
      .status_o   (status),
      .consumed_o (consumed),
      .returned_o (returned)
   );

   aifp_fifo #(.WIDTH(RSP_BITS), .DEPTH(2)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (emit && item_take),
      .wr_data ({mag, neg, status, consumed, returned}),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   // sign and size applied on the way out of the queue
   assign {head_mag, head_neg, rsp_status, rsp_consumed, rsp_returned} = rsp_data;
   assign head_signed = head_neg ? VALUE_BITS'(~head_mag + 1'b1) : head_mag;
   assign head_ext    = EXT_BITS'(head_signed);
   assign rsp_value   = result_size_ff ? head_ext[31:0] : {16'h0000, head_ext[15:0]};

endmodule

// ===== bench/ascii_integer_field_parser_tb.sv =====
`timescale 1ns / 100ps

module ascii_integer_field_parser_tb
   import aifp_pkg::*;
   ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 90;

   typedef struct {
      logic [7:0] ch;
      logic       at_end;
   } char_item_type;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
      logic [7:0]  consumed;
      logic [1:0]  returned;
   } field_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic [7:0]  req_ch = 8'd0;
   logic        req_at_end = 1'b0;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_consumed;
   logic [1:0]  rsp_returned;
   logic        empty;
   logic        pop = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   ascii_integer_field_parser uut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch), .req_at_end(req_at_end), .push(push), .full(full),
      .rsp_value(rsp_value), .rsp_status(rsp_status), .rsp_consumed(rsp_consumed),
      .rsp_returned(rsp_returned), .empty(empty), .pop(pop),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // parser model state and register copies
   phase_type   scan_phase = PH_SKIP;
   logic [31:0] acc_value = 32'd0;
   logic        acc_negative = 1'b0;
   logic        saw_sign = 1'b0;
   base_type    digit_base = BASE_DEC;
   logic [8:0]  field_len = 9'd0;
   logic [2:0]  cfg_conversion = CONV_SDEC;
   logic [7:0]  cfg_max_width = 8'd0;
   logic        cfg_result_size = 1'b1;

   char_item_type    char_stream[$];
   field_result_type awaited_fields[$];
   char_item_type    sent_item;
   field_result_type sent_result;
   field_result_type got_field;
   int send_gap = 0;
   int recv_gap = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int added_items = 0;
   bit no_idle = 1'b0;
   string hex_digits = "0123456789abcdefABCDEF";

   logic [2:0] phase_conv[PHASE_COUNT] = '{CONV_SDEC, CONV_AUTO, CONV_OCT, CONV_HEX, CONV_UDEC,
      3'd5, CONV_AUTO, CONV_HEX, 3'd7, CONV_SDEC, CONV_AUTO, CONV_UDEC};
   logic [7:0] phase_width[PHASE_COUNT] = '{8'd0, 8'd0, 8'd3, 8'd0, 8'd1, 8'd255, 8'd2,
      8'd0, 8'd0, 8'd4, 8'd0, 8'd6};
   logic       phase_size[PHASE_COUNT] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
      1'b1, 1'b1, 1'b0, 1'b1};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [4:0] digit_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      return NO_DIGIT;
   endfunction

   function automatic logic [4:0] base_radix(input base_type b);
      case (b)
         BASE_OCT: return 5'd8;
         BASE_HEX: return 5'd16;
         default: return 5'd10;
      endcase
   endfunction

   function automatic void clear_field();
      scan_phase = PH_SKIP;
      acc_value = 32'd0;
      acc_negative = 1'b0;
      saw_sign = 1'b0;
      digit_base = BASE_DEC;
      field_len = 9'd0;
   endfunction

   function automatic void bump_len();
      if (field_len != 9'h1FF) field_len++;
   endfunction

   function automatic bit width_hit();
      return cfg_max_width != 8'd0 && field_len >= {1'b0, cfg_max_width};
   endfunction

   function automatic bit close_field(input logic [1:0] st, input logic [8:0] used,
                                      input logic [1:0] back, output field_result_type r);
      logic [31:0] v;
      v = 32'd0;
      if (st == ST_OK) begin
         v = acc_value;
         if (acc_negative) v = -v;
         if (!cfg_result_size) v = v & 32'h0000_FFFF;
      end else begin
         used = 9'd0;
      end
      r.value = v;
      r.status = st;
      r.consumed = (used > 9'd255) ? 8'd255 : used[7:0];
      r.returned = back;
      clear_field();
      return 1'b1;
   endfunction

   function automatic bit check_width(output field_result_type r);
      r = '{default: '0};
      if (width_hit()) return close_field(ST_OK, field_len, 2'd0, r);
      return 1'b0;
   endfunction

   function automatic bit shift_digit(input logic [7:0] c, output field_result_type r);
      logic [4:0] b;
      logic [4:0] d;
      b = base_radix(digit_base);
      d = digit_val(c);
      if (d >= b) return close_field(ST_OK, field_len, 2'd1, r);
      bump_len();
      acc_value = acc_value * {27'd0, b} + {27'd0, d};
      scan_phase = PH_DIGITS;
      return check_width(r);
   endfunction

   function automatic bit open_number(input logic [7:0] c, output field_result_type r);
      logic [2:0] conv;
      logic [4:0] d;
      conv = (cfg_conversion > CONV_UDEC) ? CONV_SDEC : cfg_conversion;
      d = digit_val(c);
      acc_value = 32'd0;
      if ((conv == CONV_AUTO || conv == CONV_HEX) && c == "0") begin
         digit_base = (conv == CONV_AUTO) ? BASE_OCT : BASE_HEX;
         scan_phase = PH_ZERO;
         return check_width(r);
      end
      if (conv == CONV_AUTO) digit_base = (d < 5'd10) ? BASE_DEC : BASE_HEX;
      else if (conv == CONV_OCT) digit_base = BASE_OCT;
      else if (conv == CONV_HEX) digit_base = BASE_HEX;
      else digit_base = BASE_DEC;
      if (d >= base_radix(digit_base))
         return close_field(ST_NO_DIGITS, 9'd0, saw_sign ? 2'd2 : 2'd1, r);
      acc_value = {27'd0, d};
      scan_phase = PH_DIGITS;
      return check_width(r);
   endfunction

   function automatic bit parse_char(input char_item_type it, output field_result_type r);
      logic [7:0] c;
      bit fin;
      c = it.ch;
      fin = it.at_end;
      r = '{default: '0};
      case (scan_phase)
         PH_SIGN: begin
            if (fin) return close_field(ST_NO_DIGITS, 9'd0, 2'd1, r);
            bump_len();
            return open_number(c, r);
         end
         PH_ZERO: begin
            if (fin) return close_field(ST_OK, field_len, 2'd0, r);
            if (c == "x" || c == "X") begin
               bump_len();
               scan_phase = PH_AFTERX;
               if (width_hit()) return close_field(ST_OK, field_len - 9'd1, 2'd1, r);
               return 1'b0;
            end
            return shift_digit(c, r);
         end
         PH_AFTERX: begin
            if (fin) return close_field(ST_OK, field_len - 9'd1, 2'd1, r);
            if (digit_val(c) == NO_DIGIT) return close_field(ST_OK, field_len - 9'd1, 2'd2, r);
            digit_base = BASE_HEX;
            return shift_digit(c, r);
         end
         PH_DIGITS: begin
            if (fin) return close_field(ST_OK, field_len, 2'd0, r);
            return shift_digit(c, r);
         end
         default: begin
            if (fin) return close_field(ST_END_EARLY, 9'd0, 2'd0, r);
            if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return 1'b0;
            clear_field();
            bump_len();
            if (c == "+" || (c == "-" && cfg_conversion != CONV_UDEC)) begin
               saw_sign = 1'b1;
               acc_negative = (c == "-");
               scan_phase = PH_SIGN;
               if (width_hit()) return close_field(ST_NO_DIGITS, 9'd0, 2'd1, r);
               return 1'b0;
            end
            return open_number(c, r);
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         send_gap = 0;
      end else begin
         if (push && !full) begin
            sent_item = char_stream.pop_front();
            if (parse_char(sent_item, sent_result)) awaited_fields.push_back(sent_result);
            send_gap = pick_gap();
         end
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (char_stream.size() > 0) begin
            push <= 1'b1;
            req_ch <= char_stream[0].ch;
            req_at_end <= char_stream[0].at_end;
         end else begin
            push <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string why, input field_result_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: want value %h status %0d consumed %0d returned %0d",
                  $realtime, why, want.value, want.status, want.consumed, want.returned);
         $display("   got value %h status %0d consumed %0d returned %0d",
                  rsp_value, rsp_status, rsp_consumed, rsp_returned);
      end
   endtask

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         recv_gap = 0;
      end else begin
         if (pop && !empty) begin
            if (awaited_fields.size() == 0) begin
               report_mismatch("result transfer with nothing pending", '{default: '0});
            end else begin
               got_field = awaited_fields.pop_front();
               if (rsp_value !== got_field.value || rsp_status !== got_field.status ||
                   rsp_consumed !== got_field.consumed || rsp_returned !== got_field.returned)
                  report_mismatch("field mismatch", got_field);
            end
            recv_gap = pick_gap();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ascii_integer_field_parser_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic add_char(input logic [7:0] c);
      char_stream.push_back('{ch: c, at_end: 1'b0});
      added_items++;
   endtask

   task automatic add_end();
      char_stream.push_back('{ch: 8'($urandom_range(255)), at_end: 1'b1});
      added_items++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_CONVERSION: cfg_conversion = data[2:0];
         REG_MAX_WIDTH: cfg_max_width = data[7:0];
         REG_RESULT_SIZE: cfg_result_size = data[0];
         default: ;
      endcase
   endtask

   // wait until all transfers are done and the pipeline has settled
   task automatic drain();
      while (char_stream.size() != 0 || awaited_fields.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_mode(input logic [2:0] conv, input logic [7:0] width, input logic size);
      drain();
      csr_write(REG_CONVERSION, {29'd0, conv});
      csr_write(REG_MAX_WIDTH, {24'd0, width});
      csr_write(REG_RESULT_SIZE, {31'd0, size});
   endtask

   function automatic logic [7:0] pick_space();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? 8'd32 : 8'(9 + k);
   endfunction

   function automatic logic [7:0] pick_digit();
      if ($urandom_range(9) == 0) return hex_digits[$urandom_range(21)];
      case (cfg_conversion)
         CONV_OCT: return 8'("0" + $urandom_range(7));
         CONV_AUTO, CONV_HEX: return hex_digits[$urandom_range(21)];
         default: return 8'("0" + $urandom_range(9));
      endcase
   endfunction

   task automatic long_field(input int n);
      for (int i = 0; i < n; i++) add_char(8'("0" + $urandom_range(9)));
      add_char(" ");
   endtask

   task automatic gen_field();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 8) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) add_char(8'($urandom_range(255)));
         return;
      end
      if (r < 11) begin
         add_end();
         return;
      end
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) add_char(pick_space());
      r = $urandom_range(9);
      if (r < 3) add_char("+");
      else if (r < 6) add_char("-");
      r = $urandom_range(9);
      if (r < 3) begin
         add_char("0");
         add_char($urandom_range(1) ? "x" : "X");
      end else if (r < 5) begin
         add_char("0");
      end
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) add_char(pick_digit());
      r = $urandom_range(99);
      if (r < 40) add_char(pick_space());
      else if (r < 60) add_end();
      else add_char(8'($urandom_range(255)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: signed decimal, unlimited width, 32-bit result
      add_end();
      add_text(" \t-");
      add_end();
      add_text("+a");
      add_text("z");
      add_text("4294967295 ");
      add_end();

      // auto base: 0x prefix, 0x with no hex digit, 0x at end of input
      set_mode(CONV_AUTO, 8'd0, 1'b0);
      add_text("0x1Fz0xg0X");
      add_end();

      // hex with width two: width runs out on the x, then on a sign and digit
      set_mode(CONV_HEX, 8'd2, 1'b1);
      add_text("0x-5");
      add_end();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_mode(phase_conv[p], phase_width[p], phase_size[p]);
         no_idle = (p % 4 == 3);
         added_items = 0;
         if (p == 0) long_field(600);
         if (p == 5) long_field(300);
         while (added_items < PHASE_ITEMS) gen_field();
         add_end();
      end

      while (char_stream.size() != 0 || awaited_fields.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (awaited_fields.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("ascii_integer_field_parser_tb OK");
      end else begin
         $display("ascii_integer_field_parser_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== ascii_integer_field_parser.f =====
rtl/aifp_pkg.sv
rtl/aifp_fifo.sv
rtl/aifp_front.sv
rtl/aifp_back.sv
rtl/ascii_integer_field_parser.sv
bench/ascii_integer_field_parser_tb.sv
